FILE: design/prvp_pkg.sv
// Shared types and codes for the privileged register value predictor.
// Used by the controller, the datapath and the top level; no dependencies.
package prvp_pkg;

  // Command field codes
  localparam logic CMD_PREDICT = 1'b0;
  localparam logic CMD_UPDATE  = 1'b1;

  // Register kind codes
  localparam logic [1:0] KIND_STATE_WORD = 2'd0;
  localparam logic [1:0] KIND_TRAP_LEVEL = 2'd1;
  localparam logic [1:0] KIND_WINDOW     = 2'd2;

  // Field widths fixed by the item format
  localparam int VPC_W   = 64;
  localparam int VALUE_W = 12;
  localparam int TL_W    = 3;
  localparam int WIN_PTR_W = 3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clear_step;  // write one zero entry during the clearing pass
    logic capture;     // latch the accepted item and start the table reads
    logic evaluate;    // compare tags, form the result, write on update
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clear_last;  // clearing pass is at its last entry
  } ctrl_status_t;

endpackage

FILE: design/prvp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module prvp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/prvp_ctrl.sv
// Controller for the predictor: clearing pass, item handshake, sequencing.
// Depends on prvp_pkg.
module prvp_ctrl
  import prvp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  output ctrl_cmd_t    cmd,
  input  ctrl_status_t status
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       in_accept;
  logic       out_accept;

  // Take a new item when idle, or when the waiting result leaves this cycle
  assign out_valid  = (state == S_RESP);
  assign out_accept = out_valid && !out_stall;
  assign in_stall   = !((state == S_IDLE) || out_accept);
  assign in_accept  = in_valid && !in_stall;

  // Drive datapath commands
  always_comb begin
    cmd            = '0;
    cmd.clear_step = (state == S_CLEAR);
    cmd.capture    = in_accept;
    cmd.evaluate   = (state == S_LOOK);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        if (out_accept) begin
          state_next = in_accept ? S_LOOK : S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_look_to_resp: assert property (@(posedge clk) disable iff (rst)
    state == S_LOOK |=> state == S_RESP)
    else $error("lookup did not move to the response state");

  a_no_capture_in_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> state != S_CLEAR)
    else $error("item taken during the clearing pass");

  a_resp_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP && out_stall) |=> state == S_RESP)
    else $error("result dropped while the receiver stalls");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd.evaluate && cmd.capture))
    else $error("new item taken while the previous one is evaluated");
`endif

endmodule

FILE: design/prvp_datapath.sv
// Datapath for the predictor: item registers, three tagged tables, tag
// compare, window pointer arithmetic and result registers.
// Depends on prvp_pkg and prvp_ram.
module prvp_datapath
  import prvp_pkg::*;
#(
  parameter int TABLE_ENTRIES = 256,
  parameter int WINDOW_COUNT  = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_cmd_t            cmd,
  output ctrl_status_t         status,
  input  logic                 cmd_in,
  input  logic [VPC_W-1:0]     vpc,
  input  logic [1:0]           reg_kind,
  input  logic [VALUE_W-1:0]   resolved_value,
  input  logic [VALUE_W-1:0]   earlier_guess,
  input  logic [VALUE_W-1:0]   cur_state_word,
  input  logic [TL_W-1:0]      cur_trap_level,
  input  logic [WIN_PTR_W-1:0] cur_window,
  output logic [VALUE_W-1:0]   prediction,
  output logic                 table_hit
);

  // Table geometry: index above the two alignment bits, tag above the index
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int TAG_W = VPC_W - 2 - IDX_W;
  localparam int SW_W  = 1 + TAG_W + VALUE_W;
  localparam int TLE_W = 1 + TAG_W + TL_W;
  localparam int WIN_W = 1 + TAG_W + 1;
  localparam int WMOD_W = $clog2(WINDOW_COUNT);
  localparam int SUM_W  = 6;
  localparam int SUM_N  = 1 << SUM_W;

  // Item registers
  logic                 cmd_q;
  logic [1:0]           kind_q;
  logic [IDX_W-1:0]     idx_q;
  logic [TAG_W-1:0]     tag_q;
  logic [VALUE_W-1:0]   actual_q;
  logic [VALUE_W-1:0]   guess_q;
  logic [VALUE_W-1:0]   cur_sw_q;
  logic [TL_W-1:0]      cur_tl_q;
  logic [WIN_PTR_W-1:0] cur_win_q;

  // Clearing pass counter
  logic [IDX_W-1:0] clr_cnt;

  // Table ports
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] waddr;
  logic             sw_we;
  logic             tl_we;
  logic             win_we;
  logic [SW_W-1:0]  sw_wdata;
  logic [TLE_W-1:0] tl_wdata;
  logic [WIN_W-1:0] win_wdata;
  logic [SW_W-1:0]  sw_rdata;
  logic [TLE_W-1:0] tl_rdata;
  logic [WIN_W-1:0] win_rdata;

  // Evaluation signals
  logic               sw_hit;
  logic               tl_hit;
  logic               win_hit;
  logic               win_dir_up;
  logic [SUM_W-1:0]   win_sum;
  logic [WMOD_W-1:0]  win_mod [SUM_N];
  logic [VALUE_W-1:0] sel_value;
  logic               hit_value;
  logic               is_update;

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q     <= cmd_in;
      kind_q    <= reg_kind;
      idx_q     <= vpc[IDX_W+1:2];
      tag_q     <= vpc[VPC_W-1:IDX_W+2];
      actual_q  <= resolved_value;
      guess_q   <= earlier_guess;
      cur_sw_q  <= cur_state_word;
      cur_tl_q  <= cur_trap_level;
      cur_win_q <= cur_window;
    end
  end

  // Advance the clearing pass one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign status.clear_last = (clr_cnt == IDX_W'(TABLE_ENTRIES - 1));

  // Read at the index of the incoming item
  assign raddr = vpc[IDX_W+1:2];

  // Window direction: wrap from zero to the top counts as a decrement
  always_comb begin
    if ((guess_q == '0) && (actual_q == VALUE_W'(WINDOW_COUNT - 1))) begin
      win_dir_up = 1'b0;
    end else begin
      win_dir_up = (guess_q < actual_q);
    end
  end

  // Write the table of the item's kind on update, or all tables with zeros while clearing
  assign is_update = cmd.evaluate && (cmd_q == CMD_UPDATE);
  assign waddr     = cmd.clear_step ? clr_cnt : idx_q;
  assign sw_we     = cmd.clear_step || (is_update && (kind_q == KIND_STATE_WORD));
  assign tl_we     = cmd.clear_step || (is_update && (kind_q == KIND_TRAP_LEVEL));
  assign win_we    = cmd.clear_step || (is_update && (kind_q == KIND_WINDOW));
  assign sw_wdata  = cmd.clear_step ? '0 : {1'b1, tag_q, actual_q};
  assign tl_wdata  = cmd.clear_step ? '0 : {1'b1, tag_q, actual_q[TL_W-1:0]};
  assign win_wdata = cmd.clear_step ? '0 : {1'b1, tag_q, win_dir_up};

  prvp_ram #(.WIDTH(SW_W), .DEPTH(TABLE_ENTRIES)) u_sw_ram (
    .clk   (clk),
    .we    (sw_we),
    .waddr (waddr),
    .wdata (sw_wdata),
    .re    (cmd.capture),
    .raddr (raddr),
    .rdata (sw_rdata)
  );

  prvp_ram #(.WIDTH(TLE_W), .DEPTH(TABLE_ENTRIES)) u_tl_ram (
    .clk   (clk),
    .we    (tl_we),
    .waddr (waddr),
    .wdata (tl_wdata),
    .re    (cmd.capture),
    .raddr (raddr),
    .rdata (tl_rdata)
  );

  prvp_ram #(.WIDTH(WIN_W), .DEPTH(TABLE_ENTRIES)) u_win_ram (
    .clk   (clk),
    .we    (win_we),
    .waddr (waddr),
    .wdata (win_wdata),
    .re    (cmd.capture),
    .raddr (raddr),
    .rdata (win_rdata)
  );

  // Tag compare against the entry read before any write of this item
  assign sw_hit  = sw_rdata[SW_W-1]   && (sw_rdata[SW_W-2 -: TAG_W] == tag_q);
  assign tl_hit  = tl_rdata[TLE_W-1]  && (tl_rdata[TLE_W-2 -: TAG_W] == tag_q);
  assign win_hit = win_rdata[WIN_W-1] && (win_rdata[WIN_W-2 -: TAG_W] == tag_q);

  // Residues modulo the window count, built at elaboration
  for (genvar g = 0; g < SUM_N; g++) begin : g_win_mod
    assign win_mod[g] = WMOD_W'(g % WINDOW_COUNT);
  end

  // Step the pointer up by one or down by one (as plus count minus one)
  assign win_sum = win_rdata[0] ? (SUM_W'(cur_win_q) + SUM_W'(1))
                                : (SUM_W'(cur_win_q) + SUM_W'(WINDOW_COUNT - 1));

  // Select the prediction and hit for the item's register kind; an update gives prediction 0
  always_comb begin
    sel_value = '0;
    hit_value = 1'b0;
    case (kind_q)
      KIND_STATE_WORD: begin
        hit_value = sw_hit;
        sel_value = sw_hit ? sw_rdata[VALUE_W-1:0] : cur_sw_q;
      end
      KIND_TRAP_LEVEL: begin
        hit_value = tl_hit;
        sel_value = VALUE_W'(tl_hit ? tl_rdata[TL_W-1:0] : cur_tl_q);
      end
      KIND_WINDOW: begin
        hit_value = win_hit;
        sel_value = win_hit ? VALUE_W'(win_mod[win_sum]) : VALUE_W'(cur_win_q);
      end
      default: begin
        sel_value = '0;
        hit_value = 1'b0;
      end
    endcase
    if (cmd_q == CMD_UPDATE) begin
      sel_value = '0;
    end
  end

  // Hold the result until the next item is evaluated
  always_ff @(posedge clk) begin
    if (cmd.evaluate) begin
      prediction <= sel_value;
      table_hit  <= hit_value;
    end
  end

endmodule

FILE: design/privileged_register_value_predictor_core.sv
// Privileged register value predictor, top level.
// Items enter on the in channel (in_valid / in_stall) and results leave on
// the out channel (out_valid / out_stall); an item moves when valid is high
// and stall is low. Every item gives exactly one result: a predict command
// returns the stored value on a tag hit (for the window kind, the current
// pointer stepped in the stored direction) and the current register value
// on a miss; an update writes its entry and returns prediction 0. The table
// read registers at the accepting edge and the next cycle, in the lookup
// state, does the tag compare, result and table write; out_valid rises as
// the result registers load. A new item is not taken during the lookup:
// an item's table read must follow the previous item's table write, so a new
// item is taken in the same cycle the previous result is taken. While
// out_stall is high the result holds and in_stall stays high. After reset a
// clearing pass writes every table entry to zero, one entry a cycle; in_stall
// is high until it ends. TABLE_ENTRIES must be a power of two.
// Depends on prvp_pkg, prvp_ctrl, prvp_datapath and prvp_ram.
module privileged_register_value_predictor_core
  import prvp_pkg::*;
#(
  parameter int TABLE_ENTRIES = 256,
  parameter int WINDOW_COUNT  = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 cmd,
  input  logic [VPC_W-1:0]     vpc,
  input  logic [1:0]           reg_kind,
  input  logic [VALUE_W-1:0]   resolved_value,
  input  logic [VALUE_W-1:0]   earlier_guess,
  input  logic [VALUE_W-1:0]   cur_state_word,
  input  logic [TL_W-1:0]      cur_trap_level,
  input  logic [WIN_PTR_W-1:0] cur_window,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [VALUE_W-1:0]   prediction,
  output logic                 table_hit
);

  ctrl_cmd_t    ctrl_cmd;
  ctrl_status_t ctrl_status;

  prvp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (ctrl_cmd),
    .status    (ctrl_status)
  );

  prvp_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .WINDOW_COUNT  (WINDOW_COUNT)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (ctrl_cmd),
    .status         (ctrl_status),
    .cmd_in         (cmd),
    .vpc            (vpc),
    .reg_kind       (reg_kind),
    .resolved_value (resolved_value),
    .earlier_guess  (earlier_guess),
    .cur_state_word (cur_state_word),
    .cur_trap_level (cur_trap_level),
    .cur_window     (cur_window),
    .prediction     (prediction),
    .table_hit      (table_hit)
  );

endmodule
